// ----- hdl/siw64_pkg.sv -----
// siw64_pkg: types, constants and per-byte helper functions for select_in_word64.
// Standalone; imported by the select_in_word64 top level.
`timescale 1ns / 1ps

package siw64_pkg;

   localparam int WORD_W  = 64;
   localparam int RANK_W  = 6;
   localparam int BYTES   = 8;
   localparam int BNR_W   = 3;   // byte number within the word
   localparam int CNT_W   = 4;   // set bits in one byte, 0..8
   localparam int SUM_W   = 7;   // running total, 0..64

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef logic [7:0]       byte_type;
   typedef logic [BNR_W-1:0] bidx_type;

   // Set bits in one byte.
   function automatic cnt_type popcount8(input byte_type v);
      cnt_type c;
      c = '0;
      for (int k = 0; k < 8; k++) begin
         c = c + cnt_type'(v[k]);
      end
      return c;
   endfunction

   // Index of the set bit of rank r inside byte v; 0 when there is none.
   function automatic bidx_type pick_in_byte(input byte_type v, input bidx_type r);
      bidx_type pos;
      cnt_type  seen;
      logic     found;
      pos   = '0;
      seen  = '0;
      found = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (v[k] && !found) begin
            if (seen == cnt_type'(r)) begin
               pos   = bidx_type'(k);
               found = 1'b1;
            end
            seen = seen + 4'd1;
         end
      end
      return pos;
   endfunction

endpackage

// ----- hdl/select_in_word64.sv -----
// select_in_word64: broadword select of the set bit of a given rank in a 64-bit word.
// Depends on siw64_pkg for types, widths and the per-byte helper functions.
`timescale 1ns / 1ps

// Usage
//   Input channel: an item (req_word, req_rank) is taken at a rising edge with
//   start high and busy low. busy is held low: the pipeline never stalls, so
//   an item may be presented in every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle per item, with
//   rsp_position and rsp_valid_res beside it. The receiver cannot push back.
//   rsp_valid_res is 0 when req_rank is not below the population count of
//   req_word; rsp_position is then 0.
// Throughput and pipeline
//   One item per cycle sustained; four register stages carry an item from the
//   accepting edge to the result:
//     1. per-byte set-bit counts
//     2. running byte totals (eight narrow chained adds)
//     3. compare against rank, lowest hit byte, local rank in that byte
//     4. pick within the byte, output register
// Reset
//   Synchronous, active high. Clears the stage valid bits only; items in
//   flight are dropped and no strobe appears until new items arrive.

module select_in_word64
   import siw64_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [WORD_W-1:0] req_word,
   input  logic [RANK_W-1:0] req_rank,
   output logic              rsp_strobe,
   output logic [RANK_W-1:0] rsp_position,
   output logic              rsp_valid_res
);

   // ---------------- stage 1: per-byte counts ----------------
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff;
   logic [RANK_W-1:0] s1_rank_ff;
   cnt_type           s1_cnt_ff [BYTES];
   cnt_type           s1_cnt_in [BYTES];

   // ---------------- stage 2: running totals ----------------
   logic              s2_valid_ff;
   logic [WORD_W-1:0] s2_word_ff;
   logic [RANK_W-1:0] s2_rank_ff;
   sum_type           s2_sum_ff [BYTES];
   sum_type           s2_sum_in [BYTES];

   // ---------------- stage 3: byte choice ----------------
   logic              s3_valid_ff;
   logic              s3_hit_ff, s3_hit_in;
   bidx_type          s3_bnr_ff, s3_bnr_in;
   byte_type          s3_local_ff, s3_local_in;
   bidx_type          s3_lrank_ff, s3_lrank_in;
   bidx_type          s3_below;    // low bits of the total below the chosen byte

   // ---------------- stage 4: output ----------------
   logic              rsp_strobe_ff;
   logic [RANK_W-1:0] rsp_position_ff, rsp_position_in;
   logic              rsp_valid_res_ff;

   // Never holds items off.
   assign busy        = 1'b0;
   assign s1_valid_in = start & ~busy;

   always_comb begin
      for (int i = 0; i < BYTES; i++) begin
         s1_cnt_in[i] = popcount8(req_word[i*8 +: 8]);
      end
   end

   // Running totals: byte i holds set bits in bytes 0..i.
   always_comb begin
      sum_type acc;
      acc = '0;
      for (int i = 0; i < BYTES; i++) begin
         acc          = acc + sum_type'(s1_cnt_ff[i]);
         s2_sum_in[i] = acc;
      end
   end

   // Lowest byte whose running total exceeds the rank; top byte by default,
   // which is right whenever the rank is below the total.
   always_comb begin
      sum_type rank_ext;
      rank_ext  = sum_type'(s2_rank_ff);
      s3_bnr_in = bidx_type'(BYTES - 1);
      for (int i = BYTES - 2; i >= 0; i--) begin
         if (s2_sum_ff[i] > rank_ext) begin
            s3_bnr_in = bidx_type'(i);
         end
      end
      s3_hit_in   = rank_ext < s2_sum_ff[BYTES-1];
      s3_below    = (s3_bnr_in == '0) ? '0 : s2_sum_ff[s3_bnr_in - 3'd1][BNR_W-1:0];
      s3_local_in = s2_word_ff[{s3_bnr_in, 3'b000} +: 8];
      s3_lrank_in = s2_rank_ff[BNR_W-1:0] - s3_below;
   end

   assign rsp_position_in = s3_hit_ff
                          ? {s3_bnr_ff, pick_in_byte(s3_local_ff, s3_lrank_ff)}
                          : '0;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         rsp_strobe_ff <= s3_valid_ff;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      s1_word_ff       <= req_word;
      s1_rank_ff       <= req_rank;
      s1_cnt_ff        <= s1_cnt_in;
      s2_word_ff       <= s1_word_ff;
      s2_rank_ff       <= s1_rank_ff;
      s2_sum_ff        <= s2_sum_in;
      s3_hit_ff        <= s3_hit_in;
      s3_bnr_ff        <= s3_bnr_in;
      s3_local_ff      <= s3_local_in;
      s3_lrank_ff      <= s3_lrank_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_valid_res_ff <= s3_hit_ff;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

endmodule

// ----- verif/siw64_checker.sv -----
// siw64_checker: predicts select_in_word64 results for every accepted item and
// compares them with the result channel. Depends on siw64_pkg for the widths.
`timescale 1ns / 1ps

module siw64_checker
   import siw64_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [WORD_W-1:0] req_word,
   input  logic [RANK_W-1:0] req_rank,
   input  logic              rsp_strobe,
   input  logic [RANK_W-1:0] rsp_position,
   input  logic              rsp_valid_res,
   output int                mismatch_count,
   output int                selects_pending
);

   typedef struct packed {
      logic [RANK_W-1:0] position;
      logic              found;
   } select_result_type;

   select_result_type expected_selects[$];

   // Bit index of the set bit with `rank` set bits below it; not found when
   // the word holds no more than `rank` set bits, position then 0.
   function automatic select_result_type select_bit_of_rank(input logic [WORD_W-1:0] word,
                                                            input logic [RANK_W-1:0] rank);
      select_result_type res;
      int                seen;
      res  = '0;
      seen = 0;
      for (int k = 0; k < WORD_W; k++) begin
         if (word[k]) begin
            if (seen == int'(rank) && !res.found) begin
               res.position = RANK_W'(k);
               res.found    = 1'b1;
            end
            seen++;
         end
      end
      return res;
   endfunction

   initial mismatch_count = 0;

   always @(posedge clock) begin
      select_result_type exp_res;
      if (!reset) begin
         // results first: latency rules out a result for this edge's item
         if (rsp_strobe) begin
            if (expected_selects.size() == 0) begin
               $display("%t: unexpected result position=%0d valid_res=%0b",
                        $realtime, rsp_position, rsp_valid_res);
               mismatch_count++;
            end else begin
               exp_res = expected_selects.pop_front();
               if (rsp_position !== exp_res.position) begin
                  $display("%t: position mismatch: expected %0d, actual %0d",
                           $realtime, exp_res.position, rsp_position);
                  mismatch_count++;
               end
               if (rsp_valid_res !== exp_res.found) begin
                  $display("%t: valid_res mismatch: expected %0b, actual %0b",
                           $realtime, exp_res.found, rsp_valid_res);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            expected_selects.push_back(select_bit_of_rank(req_word, req_rank));
      end
      selects_pending <= expected_selects.size();
   end

endmodule

// ----- verif/tb_select_in_word64.sv -----
// tb_select_in_word64: stimulus and verdict for select_in_word64.
// Depends on siw64_pkg, select_in_word64 and siw64_checker.
`timescale 1ns / 1ps

module tb_select_in_word64
   import siw64_pkg::*;
();

   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 8;     // four-stage pipeline, with margin
   localparam int GAP_PERCENT  = 31;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              start         = 1'b0;
   logic [WORD_W-1:0] req_word      = '0;
   logic [RANK_W-1:0] req_rank      = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [RANK_W-1:0] rsp_position;
   logic              rsp_valid_res;
   int                mismatch_count;
   int                selects_pending;

   always #4 clock = ~clock;

   select_in_word64 DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .req_rank      (req_rank),
      .rsp_strobe    (rsp_strobe),
      .rsp_position  (rsp_position),
      .rsp_valid_res (rsp_valid_res)
   );

   siw64_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_word        (req_word),
      .req_rank        (req_rank),
      .rsp_strobe      (rsp_strobe),
      .rsp_position    (rsp_position),
      .rsp_valid_res   (rsp_valid_res),
      .mismatch_count  (mismatch_count),
      .selects_pending (selects_pending)
   );

   // Present one item. Called at a rising edge; returns at the edge that
   // took the item, so the next call can keep start high without a gap.
   // busy is looked at on the falling edge, well away from the rising one.
   task automatic send_query(input logic [WORD_W-1:0] word,
                             input logic [RANK_W-1:0] rank,
                             input bit                no_gaps);
      if (!no_gaps) begin
         while ($urandom_range(99, 0) < GAP_PERCENT) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_word <= word;
      req_rank <= rank;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // Word shapes: plain random, sparse, dense, a few lone bits, a single
   // busy byte lane, and the all-zero / all-one corners.
   function automatic logic [WORD_W-1:0] random_word();
      logic [WORD_W-1:0] w;
      w = '0;
      case ($urandom_range(5, 0))
         0: w = {$urandom, $urandom};
         1: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         2: w = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
         3: begin
            repeat ($urandom_range(4, 1)) w[$urandom_range(WORD_W-1, 0)] = 1'b1;
         end
         4: w = {$urandom, $urandom} & (64'hFF << (8 * $urandom_range(BYTES-1, 0)));
         default: w = $urandom_range(1, 0) ? '0 : '1;
      endcase
      return w;
   endfunction

   // Mostly ranks that hit a set bit; the rest sit right on the population
   // count (first miss) or are drawn blind.
   function automatic logic [RANK_W-1:0] random_rank(input logic [WORD_W-1:0] w);
      int pc;
      pc = $countones(w);
      if (pc != 0 && $urandom_range(99, 0) < 75)
         return RANK_W'($urandom_range(pc - 1, 0));
      if (pc < 64 && $urandom_range(1, 0) == 1)
         return RANK_W'(pc);
      return RANK_W'($urandom_range(63, 0));
   endfunction

   initial begin
      logic [WORD_W-1:0] w;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed corners
      send_query(64'h0, 6'd0, 1'b0);                    // empty word
      send_query(64'h0, 6'd63, 1'b0);
      send_query('1, 6'd0, 1'b0);                       // full word, both ends
      send_query('1, 6'd63, 1'b0);
      send_query('1, 6'd32, 1'b0);
      send_query(64'h1, 6'd0, 1'b0);                    // lowest bit only
      send_query(64'h8000_0000_0000_0000, 6'd0, 1'b0);  // top bit only
      send_query(64'h8000_0000_0000_0000, 6'd1, 1'b0);  // rank equals count
      send_query(64'h8000_0000_0000_0001, 6'd1, 1'b1);
      send_query(64'hAAAA_AAAA_AAAA_AAAA, 6'd31, 1'b1);
      send_query(64'hAAAA_AAAA_AAAA_AAAA, 6'd32, 1'b1);
      send_query(64'h5555_5555_5555_5555, 6'd0, 1'b1);
      send_query(64'h0101_0101_0101_0101, 6'd7, 1'b0);  // one bit per byte
      send_query(64'h8080_8080_8080_8080, 6'd7, 1'b0);
      send_query(64'h8080_8080_8080_8080, 6'd4, 1'b0);
      send_query(64'hFF00_0000_0000_0000, 6'd7, 1'b0);  // all in top byte
      send_query(64'hFF00_0000_0000_0000, 6'd8, 1'b0);
      send_query(64'h0000_0000_0000_00FF, 6'd5, 1'b0);
      send_query(64'h00FF_00FF_00FF_00FF, 6'd17, 1'b0);
      send_query(64'hF000_0000_0000_000F, 6'd4, 1'b0);  // skips six empty bytes
      send_query(64'h7FFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
      send_query(64'hFFFF_FFFF_FFFF_FFFE, 6'd62, 1'b0);

      // Random part; a stretch in the middle runs back to back
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         w = random_word();
         send_query(w, random_rank(w), n >= 400 && n < 600);
      end
      start <= 1'b0;

      while (selects_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && selects_pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: a time limit far above a slow but correct run
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
